// ----- hw/rtl/bccs_pkg.sv -----
// Shared types and constants of the 2x2 contingency score pipeline.
// No dependencies; every other file of the block imports this package.
package bccs_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int FIELD_BITS     = 24;
	localparam int SCORE_BITS     = 48;
	localparam int RATIO_BITS     = 17;

	localparam logic [RATIO_BITS-1:0] RATIO_ONE   = 17'h10000;
	localparam logic [RATIO_BITS-1:0] RATIO_RESET = 17'h08000;

	typedef enum logic [3:0] {
		OP_ACC      = 4'd0,
		OP_BASER    = 4'd1,
		OP_FMEAN    = 4'd2,
		OP_FBIAS    = 4'd3,
		OP_PODY     = 4'd4,
		OP_PODN     = 4'd5,
		OP_POFD     = 4'd6,
		OP_FAR      = 4'd7,
		OP_CSI      = 4'd8,
		OP_GSS      = 4'd9,
		OP_HK       = 4'd10,
		OP_HSS      = 4'd11,
		OP_ODDS     = 4'd12,
		OP_ORSS     = 4'd13,
		OP_COSTLOSS = 4'd14
	} op_t;

	// status that travels with a ratio through the divider
	typedef struct packed {
		logic neg;
		logic undef;
		logic sat_pre;
	} flags_t;

	// width of numerator and denominator terms for a given count width
	function automatic int wide_bits(int cb);
		return (2 * cb + 5 > cb + 19) ? 2 * cb + 5 : cb + 19;
	endfunction

endpackage

// ----- hw/rtl/binary_contingency_skill_scores.sv -----
// Top level of the 2x2 contingency table score pipeline.
// Depends on bccs_pkg, bccs_front, bccs_div_stage and bccs_round.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  input    | in_valid / in_stall     | operation, hits, false_alarms, misses,
//           |                         | correct_negatives
//  result   | out_valid / out_stall   | score, undefined, saturated
//  config   | cfg_wr_en               | cfg_wr_data (cost_loss_ratio)
//
// One table per cycle while out_stall does not hold the output. Stages: 5 front stages, 48 divider
// stages (one quotient bit each), one output register.
// Reset clears every stage's valid bit and loads the cost/loss ratio 0.5.
// A stage holds only when its successor is full and held, so bubbles close up
// and a waiting result does not stop new tables until the pipeline is full.
module binary_contingency_skill_scores #(
	parameter int COUNT_BITS = bccs_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = bccs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [3:0]                        operation,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   hits,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   false_alarms,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   misses,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   correct_negatives,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bccs_pkg::SCORE_BITS-1:0] score,
	output logic                              undefined,
	output logic                              saturated,
	input  logic                              cfg_wr_en,
	input  logic [bccs_pkg::RATIO_BITS-1:0]   cfg_wr_data
);
	import bccs_pkg::*;

	localparam int NW = wide_bits(COUNT_BITS);
	localparam int QB = SCORE_BITS;

	logic [RATIO_BITS-1:0] ratio_q;
	logic in_ready;

	// hold the cost/loss ratio
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_wr_en) begin
			ratio_q <= cfg_wr_data;
		end
	end

	logic          v_c     [QB+1];
	logic          rdy_c   [QB+1];
	flags_t        flags_c [QB+1];
	logic [NW:0]   d_c     [QB+1];
	logic [NW:0]   rem_c   [QB+1];
	logic [QB-1:0] work_c  [QB+1];

	bccs_front #(
		.COUNT_BITS (COUNT_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.hits              (hits),
		.false_alarms      (false_alarms),
		.misses            (misses),
		.correct_negatives (correct_negatives),
		.ratio             (ratio_q),
		.out_valid         (v_c[0]),
		.out_ready         (rdy_c[0]),
		.out_flags         (flags_c[0]),
		.out_d             (d_c[0]),
		.out_rem           (rem_c[0]),
		.out_work          (work_c[0])
	);

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k < QB; k++) begin : g_div
		bccs_div_stage #(
			.COUNT_BITS (COUNT_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[k]),
			.in_ready  (rdy_c[k]),
			.in_flags  (flags_c[k]),
			.in_d      (d_c[k]),
			.in_rem    (rem_c[k]),
			.in_work   (work_c[k]),
			.out_valid (v_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.out_flags (flags_c[k+1]),
			.out_d     (d_c[k+1]),
			.out_rem   (rem_c[k+1]),
			.out_work  (work_c[k+1])
		);
	end

	bccs_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_c[QB]),
		.in_ready  (rdy_c[QB]),
		.in_flags  (flags_c[QB]),
		.in_work   (work_c[QB]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.score     (score),
		.undefined (undefined),
		.saturated (saturated)
	);

	assign in_stall = !in_ready;

	// an empty output register leaves the whole chain free to advance
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output register is empty");

endmodule

// ----- hw/rtl/bccs_front.sv -----
// Front stages: sums, products, term selection, magnitudes, divider setup.
// Depends on bccs_pkg.
module bccs_front #(
	parameter int COUNT_BITS = bccs_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = bccs_pkg::FRAC_BITS_DEF,
	localparam int NW = bccs_pkg::wide_bits(COUNT_BITS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [3:0]                        operation,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   hits,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   false_alarms,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   misses,
	input  logic [bccs_pkg::FIELD_BITS-1:0]   correct_negatives,
	input  logic [bccs_pkg::RATIO_BITS-1:0]   ratio,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bccs_pkg::flags_t                  out_flags,
	output logic [NW:0]                       out_d,
	output logic [NW:0]                       out_rem,
	output logic [bccs_pkg::SCORE_BITS-1:0]   out_work
);
	import bccs_pkg::*;

	localparam int CB = COUNT_BITS;
	localparam int SB = CB + 2;
	localparam int QB = SCORE_BITS;
	localparam int TW = NW + 1 + QB;

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// take the low count bits of each field
	logic [FIELD_BITS+CB-1:0] a_x, b_x, c_x, d_x;
	logic [CB-1:0] a_in, b_in, c_in, d_in;
	assign a_x  = {{CB{1'b0}}, hits};
	assign b_x  = {{CB{1'b0}}, false_alarms};
	assign c_x  = {{CB{1'b0}}, misses};
	assign d_x  = {{CB{1'b0}}, correct_negatives};
	assign a_in = a_x[CB-1:0];
	assign b_in = b_x[CB-1:0];
	assign c_in = c_x[CB-1:0];
	assign d_in = d_x[CB-1:0];

	// each stage advances when empty or when its successor advances
	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: marginal sums
	logic [3:0] op_s1;
	logic [CB-1:0] a_s1, b_s1, c_s1, d_s1;
	logic [SB-1:0] ab_s1, ac_s1, bd_s1, cd_s1, ad_s1, abc_s1, n_s1;
	logic [RATIO_BITS-1:0] r_s1, rm_s1;
	logic rge_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1  <= operation;
			a_s1   <= a_in;
			b_s1   <= b_in;
			c_s1   <= c_in;
			d_s1   <= d_in;
			ab_s1  <= SB'(a_in) + SB'(b_in);
			ac_s1  <= SB'(a_in) + SB'(c_in);
			bd_s1  <= SB'(b_in) + SB'(d_in);
			cd_s1  <= SB'(c_in) + SB'(d_in);
			ad_s1  <= SB'(a_in) + SB'(d_in);
			abc_s1 <= SB'(a_in) + SB'(b_in) + SB'(c_in);
			n_s1   <= SB'(a_in) + SB'(b_in) + SB'(c_in) + SB'(d_in);
			r_s1   <= ratio;
			rge_s1 <= ratio >= RATIO_ONE;
			rm_s1  <= (ratio >= RATIO_ONE) ? ratio - RATIO_ONE : RATIO_ONE - ratio;
		end
	end

	// stage 2: products
	logic [3:0] op_s2;
	logic [CB-1:0] a_s2, b_s2, c_s2, d_s2;
	logic [SB-1:0] ab_s2, ac_s2, bd_s2, ad_s2, abc_s2, n_s2;
	logic n0_s2, odd0_s2, rge_s2;
	logic [NW-1:0] pad_s2, pbc_s2, pacbd_s2, paccd_s2, pabbd_s2, pabac_s2;
	logic [NW-1:0] pan_s2, pabcn_s2, prn_s2, prcd_s2, prbd_s2, prab_s2, pacrm_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2    <= op_s1;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			d_s2     <= d_s1;
			ab_s2    <= ab_s1;
			ac_s2    <= ac_s1;
			bd_s2    <= bd_s1;
			ad_s2    <= ad_s1;
			abc_s2   <= abc_s1;
			n_s2     <= n_s1;
			n0_s2    <= n_s1 == '0;
			odd0_s2  <= (b_s1 == '0) || (c_s1 == '0) || (d_s1 == '0);
			rge_s2   <= rge_s1;
			pad_s2   <= NW'(a_s1) * NW'(d_s1);
			pbc_s2   <= NW'(b_s1) * NW'(c_s1);
			pacbd_s2 <= NW'(ac_s1) * NW'(bd_s1);
			paccd_s2 <= NW'(ac_s1) * NW'(cd_s1);
			pabbd_s2 <= NW'(ab_s1) * NW'(bd_s1);
			pabac_s2 <= NW'(ab_s1) * NW'(ac_s1);
			pan_s2   <= NW'(a_s1) * NW'(n_s1);
			pabcn_s2 <= NW'(abc_s1) * NW'(n_s1);
			prn_s2   <= NW'(r_s1) * NW'(n_s1);
			prcd_s2  <= NW'(r_s1) * NW'(cd_s1);
			prbd_s2  <= NW'(r_s1) * NW'(bd_s1);
			prab_s2  <= NW'(r_s1) * NW'(ab_s1);
			pacrm_s2 <= NW'(ac_s1) * NW'(rm_s1);
		end
	end

	// stage 3: pick numerator and denominator terms for the code
	logic [NW-1:0] np_c, nn_c, dp_c, dn_c;
	logic bad_c;
	logic [NW-1:0] a16, c16, ac16;

	assign a16  = NW'(a_s2) << 16;
	assign c16  = NW'(c_s2) << 16;
	assign ac16 = NW'(ac_s2) << 16;

	always_comb begin
		np_c  = '0;
		nn_c  = '0;
		dp_c  = '0;
		dn_c  = '0;
		bad_c = 1'b0;
		unique case (op_t'(op_s2))
			OP_ACC: begin
				np_c = NW'(ad_s2); dp_c = NW'(n_s2); bad_c = n0_s2;
			end
			OP_BASER: begin
				np_c = NW'(ac_s2); dp_c = NW'(n_s2); bad_c = n0_s2;
			end
			OP_FMEAN: begin
				np_c = NW'(ab_s2); dp_c = NW'(n_s2); bad_c = n0_s2;
			end
			OP_FBIAS: begin
				np_c = NW'(ab_s2); dp_c = NW'(ac_s2);
			end
			OP_PODY: begin
				np_c = NW'(a_s2); dp_c = NW'(ac_s2);
			end
			OP_PODN: begin
				np_c = NW'(d_s2); dp_c = NW'(bd_s2);
			end
			OP_POFD: begin
				np_c = NW'(b_s2); dp_c = NW'(bd_s2);
			end
			OP_FAR: begin
				np_c = NW'(b_s2); dp_c = NW'(ab_s2);
			end
			OP_CSI: begin
				np_c = NW'(a_s2); dp_c = NW'(abc_s2);
			end
			OP_GSS: begin
				np_c = pan_s2; nn_c = pabac_s2;
				dp_c = pabcn_s2; dn_c = pabac_s2; bad_c = n0_s2;
			end
			OP_HK: begin
				np_c = pad_s2; nn_c = pbc_s2; dp_c = pacbd_s2;
			end
			OP_HSS: begin
				np_c = pad_s2 << 1; nn_c = pbc_s2 << 1; dp_c = paccd_s2 + pabbd_s2;
			end
			OP_ODDS: begin
				np_c = pad_s2; dp_c = pbc_s2; bad_c = odd0_s2;
			end
			OP_ORSS: begin
				np_c = pad_s2; nn_c = pbc_s2; dp_c = pad_s2 + pbc_s2;
			end
			OP_COSTLOSS: begin
				bad_c = n0_s2;
				if (prn_s2 < ac16) begin
					np_c = c16; nn_c = prcd_s2; dn_c = prbd_s2;
				end else if (rge_s2) begin
					np_c = prab_s2; nn_c = a16; dp_c = pacrm_s2;
				end else begin
					np_c = prab_s2; nn_c = a16; dn_c = pacrm_s2;
				end
			end
			default: begin
				bad_c = 1'b1;
			end
		endcase
	end

	logic [NW-1:0] np_s3, nn_s3, dp_s3, dn_s3;
	logic bad_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			np_s3  <= np_c;
			nn_s3  <= nn_c;
			dp_s3  <= dp_c;
			dn_s3  <= dn_c;
			bad_s3 <= bad_c;
		end
	end

	// stage 4: magnitudes and sign of the ratio
	logic [NW-1:0] nm_s4, dm_s4;
	logic neg_s4, undef_s4;
	logic nneg_c, dneg_c;
	logic [NW-1:0] nm_c, dm_c;

	assign nneg_c = np_s3 < nn_s3;
	assign dneg_c = dp_s3 < dn_s3;
	assign nm_c   = nneg_c ? nn_s3 - np_s3 : np_s3 - nn_s3;
	assign dm_c   = dneg_c ? dn_s3 - dp_s3 : dp_s3 - dn_s3;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			nm_s4    <= nm_c;
			dm_s4    <= dm_c;
			neg_s4   <= nneg_c != dneg_c;
			undef_s4 <= bad_s3 || (dm_c == '0);
		end
	end

	// stage 5: rounding offset, doubled divisor, overflow check
	logic [TW-1:0] top_c;
	logic [NW:0] dd_c;

	assign top_c = (TW'(nm_s4) << (FRAC_BITS + 1)) + TW'(dm_s4);
	assign dd_c  = {dm_s4, 1'b0};

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			out_flags.neg     <= neg_s4;
			out_flags.undef   <= undef_s4;
			out_flags.sat_pre <= top_c[TW-1:QB] >= dd_c;
			out_d             <= dd_c;
			out_rem           <= top_c[TW-1:QB];
			out_work          <= top_c[QB-1:0];
		end
	end

	assign out_valid = v_s5;

endmodule

// ----- hw/rtl/bccs_div_stage.sv -----
// One restoring division step: one quotient bit per pipeline stage.
// Depends on bccs_pkg.
module bccs_div_stage #(
	parameter int COUNT_BITS = bccs_pkg::COUNT_BITS_DEF,
	localparam int NW = bccs_pkg::wide_bits(COUNT_BITS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bccs_pkg::flags_t                  in_flags,
	input  logic [NW:0]                       in_d,
	input  logic [NW:0]                       in_rem,
	input  logic [bccs_pkg::SCORE_BITS-1:0]   in_work,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bccs_pkg::flags_t                  out_flags,
	output logic [NW:0]                       out_d,
	output logic [NW:0]                       out_rem,
	output logic [bccs_pkg::SCORE_BITS-1:0]   out_work
);
	import bccs_pkg::*;

	localparam int QB = SCORE_BITS;

	logic v_q;
	logic [NW+1:0] rem2;
	logic ge;
	logic [NW+1:0] diff;

	assign in_ready = !v_q || out_ready;

	// shift in the next dividend bit, subtract when it fits
	assign rem2 = {in_rem, in_work[QB-1]};
	assign ge   = rem2 >= {1'b0, in_d};
	assign diff = rem2 - {1'b0, in_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_flags <= in_flags;
			out_d     <= in_d;
			out_rem   <= ge ? diff[NW:0] : rem2[NW:0];
			out_work  <= {in_work[QB-2:0], ge};
		end
	end

	assign out_valid = v_q;

	// remainder stays below the divisor for a live, in-range ratio
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && !out_flags.undef && !out_flags.sat_pre |-> out_rem < out_d)
		else $error("division remainder reached the divisor");

endmodule

// ----- hw/rtl/bccs_round.sv -----
// Output register: clamp, sign and undefined handling of the quotient.
// Depends on bccs_pkg.
module bccs_round (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bccs_pkg::flags_t                  in_flags,
	input  logic [bccs_pkg::SCORE_BITS-1:0]   in_work,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [bccs_pkg::SCORE_BITS-1:0] score,
	output logic                              undefined,
	output logic                              saturated
);
	import bccs_pkg::*;

	localparam int QB = SCORE_BITS;

	logic v_q;
	logic [QB-1:0] lim;
	logic sat_c;
	logic [QB-1:0] mag;

	assign in_ready = !v_q || !out_stall;

	// clamp to the positive or negative limit
	assign lim   = in_flags.neg ? (QB'(1) << (QB - 1)) : (QB'(1) << (QB - 1)) - QB'(1);
	assign sat_c = in_flags.sat_pre || (in_work > lim);
	assign mag   = sat_c ? lim : in_work;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (in_flags.undef) begin
				score     <= '0;
				undefined <= 1'b1;
				saturated <= 1'b0;
			end else begin
				score     <= in_flags.neg ? -$signed(mag) : $signed(mag);
				undefined <= 1'b0;
				saturated <= sat_c;
			end
		end
	end

	assign out_valid = v_q;

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && undefined |-> score == '0 && !saturated)
		else $error("undefined result carries a score");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			score == {1'b0, {(QB-1){1'b1}}} || score == {1'b1, {(QB-1){1'b0}}})
		else $error("saturated result is not at a limit");

endmodule
